// ===== rtl/cls_pkg.sv =====
// Shared types and constants for the colour literal scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package cls_pkg;

    localparam int LINE_NUMBER_BITS = 24;
    localparam int COLUMN_BITS      = 16;
    localparam int LIMIT_BITS       = 8;
    localparam int HEX_RUN_BITS     = 3;

    localparam logic [LIMIT_BITS-1:0] SNIPPET_LIMIT_RESET = LIMIT_BITS'(60);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A       = 8'h61;
    localparam logic [7:0] CH_LO_B       = 8'h62;
    localparam logic [7:0] CH_LO_F       = 8'h66;
    localparam logic [7:0] CH_LO_G       = 8'h67;
    localparam logic [7:0] CH_LO_R       = 8'h72;
    localparam logic [7:0] CH_LO_Z       = 8'h7A;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_UP_F       = 8'h46;
    localparam logic [7:0] CH_UP_Z       = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    localparam logic [0:0] KIND_HEX  = 1'b0;
    localparam logic [0:0] KIND_CALL = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEX,
        PH_R,
        PH_RG,
        PH_RGB,
        PH_SPACES,
        PH_CALL
    } phase_t;

    typedef enum logic [1:0] {
        LEAD_WS,
        LEAD_SLASH,
        LEAD_BODY,
        LEAD_COMMENT
    } lead_t;

    // One classified character as it travels from front to back
    typedef struct packed {
        logic first;
        logic last;
        logic is_nl;
        logic is_hex;
        logic is_word;
        logic is_blank;
        logic is_space;
        logic is_slash;
        logic is_hash;
        logic is_lparen;
        logic is_rparen;
        logic lo_r;
        logic lo_g;
        logic lo_b;
        logic lo_a;
    } token_t;

endpackage

`default_nettype wire

// ===== rtl/cls_front.sv =====
// Front end: accepts input words and classifies each character into a token.
// Depends on cls_pkg.
`default_nettype none

module cls_front
    import cls_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] text_byte
    input  wire logic       s_tuser,    // [0] first_of_file
    input  wire logic       s_tlast,
    input  wire logic       queue_full,
    output logic            push,
    output token_t          token
);

    logic [7:0] ch;
    logic [7:0] lo;
    logic       is_digit;
    logic       is_lower;
    logic       is_upper;

    assign ch = s_tdata;
    assign lo = s_tdata | CASE_BIT;

    assign is_digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
    assign is_lower = (ch >= CH_LO_A) && (ch <= CH_LO_Z);
    assign is_upper = (ch >= CH_UP_A) && (ch <= CH_UP_Z);

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        token.first     = s_tuser;
        token.last      = s_tlast;
        token.is_nl     = (ch == CH_NL);
        token.is_hex    = is_digit || ((ch >= CH_LO_A) && (ch <= CH_LO_F))
                          || ((ch >= CH_UP_A) && (ch <= CH_UP_F));
        token.is_word   = is_digit || is_lower || is_upper || (ch == CH_UNDERSCORE);
        token.is_blank  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        token.is_space  = (ch == CH_SPACE);
        token.is_slash  = (ch == CH_SLASH);
        token.is_hash   = (ch == CH_HASH);
        token.is_lparen = (ch == CH_LPAREN);
        token.is_rparen = (ch == CH_RPAREN);
        token.lo_r      = (lo == CH_LO_R);
        token.lo_g      = (lo == CH_LO_G);
        token.lo_b      = (lo == CH_LO_B);
        token.lo_a      = (lo == CH_LO_A);
    end

endmodule

`default_nettype wire

// ===== rtl/cls_queue.sv =====
// Short token queue between the classifier and the matcher.
// Depends on cls_pkg for the token type and depth.
`default_nettype none

module cls_queue
    import cls_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire token_t push_token,
    input  wire logic   pop,
    output logic        full,
    output logic        head_valid,
    output token_t      head_token
);

    token_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cls_back.sv =====
// Back end: line/column tracking, comment-line skip, literal and call matcher
// and the output register. Depends on cls_pkg.
`default_nettype none

module cls_back
    import cls_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LIMIT_BITS-1:0] cfg_wr_data,
    input  wire logic                  head_valid,
    input  wire token_t                head_token,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [LINE_NUMBER_BITS+2*COLUMN_BITS-1:0] m_tdata,
    output logic                       m_tuser
);

    localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0]      COL_MAX  = '1;
    localparam logic [LIMIT_BITS-1:0]       SNIP_MAX = '1;
    localparam logic [HEX_RUN_BITS-1:0]     RUN_MAX  = '1;
    localparam logic [HEX_RUN_BITS-1:0]     RUN_3    = HEX_RUN_BITS'(3);
    localparam logic [HEX_RUN_BITS-1:0]     RUN_6    = HEX_RUN_BITS'(6);

    logic [LIMIT_BITS-1:0]       limit_reg;
    phase_t                      phase_reg, phase_next;
    lead_t                       lead_reg, lead_next;
    logic [HEX_RUN_BITS-1:0]     run_reg, run_next;
    logic                        prev_word_reg, prev_word_next;
    logic [COLUMN_BITS-1:0]      start_col_reg, start_col_next;
    logic [LINE_NUMBER_BITS-1:0] line_reg, line_next;
    logic [COLUMN_BITS-1:0]      col_reg, col_next;
    logic [LIMIT_BITS-1:0]       snip_reg, snip_next;
    logic [COLUMN_BITS-1:0]      mlen_reg, mlen_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_kind_reg;
    logic [LINE_NUMBER_BITS-1:0] out_line_reg;
    logic [COLUMN_BITS-1:0]      out_col_reg;
    logic [COLUMN_BITS-1:0]      out_len_reg;

    logic                        emit;
    logic                        hit_kind;
    logic [LINE_NUMBER_BITS-1:0] hit_line;
    logic [COLUMN_BITS-1:0]      hit_col;
    logic [COLUMN_BITS-1:0]      hit_len;

    assign pop = head_valid && (!out_valid_reg || m_tready);

    // Matcher for one token; all state updates are combinational and registered together on pop
    always_comb begin
        token_t t;
        logic   fresh;
        phase_t ph_step;

        t              = head_token;
        fresh          = 1'b1;
        ph_step        = PH_IDLE;
        phase_next     = phase_reg;
        lead_next      = lead_reg;
        run_next       = run_reg;
        prev_word_next = prev_word_reg;
        start_col_next = start_col_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        snip_next      = snip_reg;
        mlen_next      = mlen_reg;
        emit           = 1'b0;
        hit_kind       = KIND_HEX;
        hit_line       = line_reg;
        hit_col        = start_col_reg;
        hit_len        = '0;

        if (t.first) begin
            line_next      = LINE_NUMBER_BITS'(1);
            col_next       = '0;
            phase_next     = PH_IDLE;
            run_next       = '0;
            prev_word_next = 1'b0;
            snip_next      = '0;
            mlen_next      = '0;
            lead_next      = LEAD_WS;
        end

        if (!t.is_nl) begin
            col_next = (col_next != COL_MAX) ? col_next + 1'b1 : COL_MAX;

            case (lead_next)
                LEAD_WS: begin
                    if (!t.is_blank) begin
                        lead_next = t.is_slash ? LEAD_SLASH : LEAD_BODY;
                    end
                end
                LEAD_SLASH: lead_next = t.is_slash ? LEAD_COMMENT : LEAD_BODY;
                default:    lead_next = lead_next;
            endcase

            if (lead_next != LEAD_COMMENT) begin
                case (phase_next)
                    PH_IDLE: fresh = 1'b1;
                    PH_HEX: begin
                        if (t.is_hex) begin
                            run_next = (run_next != RUN_MAX) ? run_next + 1'b1 : RUN_MAX;
                            fresh    = 1'b0;
                        end else begin
                            if (run_next == RUN_3 || run_next == RUN_6) begin
                                emit     = 1'b1;
                                hit_kind = KIND_HEX;
                                hit_col  = start_col_next;
                                hit_len  = COLUMN_BITS'(run_next) + 1'b1;
                            end
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_CALL: begin
                        fresh     = 1'b0;
                        mlen_next = (mlen_next != COL_MAX) ? mlen_next + 1'b1 : COL_MAX;
                        snip_next = (snip_next != SNIP_MAX) ? snip_next + 1'b1 : SNIP_MAX;
                        if (t.is_rparen || snip_next >= limit_reg) begin
                            emit       = 1'b1;
                            hit_kind   = KIND_CALL;
                            hit_col    = start_col_next;
                            hit_len    = mlen_next;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        if (phase_next == PH_R && t.lo_g) begin
                            ph_step = PH_RG;
                        end else if (phase_next == PH_RG && t.lo_b) begin
                            ph_step = PH_RGB;
                        end else if (phase_next == PH_RGB && (t.lo_a || t.is_space)) begin
                            ph_step = PH_SPACES;
                        end else if (phase_next == PH_SPACES && t.is_space) begin
                            ph_step = PH_SPACES;
                        end else if ((phase_next == PH_RGB || phase_next == PH_SPACES)
                                     && t.is_lparen) begin
                            ph_step = PH_CALL;
                        end
                        if (ph_step != PH_IDLE) begin
                            fresh      = 1'b0;
                            mlen_next  = (mlen_next != COL_MAX) ? mlen_next + 1'b1 : COL_MAX;
                            phase_next = ph_step;
                            if (ph_step == PH_CALL) begin
                                snip_next = '0;
                                // Zero limit: the snippet closes on the '(' itself
                                if (limit_reg == '0) begin
                                    emit       = 1'b1;
                                    hit_kind   = KIND_CALL;
                                    hit_col    = start_col_next;
                                    hit_len    = mlen_next;
                                    phase_next = PH_IDLE;
                                end
                            end
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase

                // The breaking byte may open a new match
                if (fresh) begin
                    if (t.is_hash) begin
                        phase_next     = PH_HEX;
                        run_next       = '0;
                        start_col_next = col_next;
                    end else if (t.lo_r && !prev_word_next) begin
                        phase_next     = PH_R;
                        start_col_next = col_next;
                        mlen_next      = COLUMN_BITS'(1);
                    end
                end
                prev_word_next = t.is_word;
            end
        end

        // Line end: a newline, or the implied one after the last byte
        if (t.is_nl || t.last) begin
            if (!emit) begin
                if (phase_next == PH_HEX && (run_next == RUN_3 || run_next == RUN_6)) begin
                    emit     = 1'b1;
                    hit_kind = KIND_HEX;
                    hit_col  = start_col_next;
                    hit_len  = COLUMN_BITS'(run_next) + 1'b1;
                end else if (phase_next == PH_CALL) begin
                    emit     = 1'b1;
                    hit_kind = KIND_CALL;
                    hit_col  = start_col_next;
                    hit_len  = mlen_next;
                end
            end
            hit_line       = line_next;
            phase_next     = PH_IDLE;
            run_next       = '0;
            snip_next      = '0;
            prev_word_next = 1'b0;
            col_next       = '0;
            lead_next      = LEAD_WS;
            line_next      = (line_next != LINE_MAX) ? line_next + 1'b1 : LINE_MAX;
        end else begin
            hit_line = line_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (pop && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= SNIPPET_LIMIT_RESET;
            phase_reg     <= PH_IDLE;
            lead_reg      <= LEAD_WS;
            run_reg       <= '0;
            prev_word_reg <= 1'b0;
            start_col_reg <= '0;
            line_reg      <= LINE_NUMBER_BITS'(1);
            col_reg       <= '0;
            snip_reg      <= '0;
            mlen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (pop) begin
                phase_reg     <= phase_next;
                lead_reg      <= lead_next;
                run_reg       <= run_next;
                prev_word_reg <= prev_word_next;
                start_col_reg <= start_col_next;
                line_reg      <= line_next;
                col_reg       <= col_next;
                snip_reg      <= snip_next;
                mlen_reg      <= mlen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_kind_reg <= hit_kind;
            out_line_reg <= hit_line;
            out_col_reg  <= hit_col;
            out_len_reg  <= hit_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_len_reg, out_col_reg, out_line_reg};

endmodule

`default_nettype wire

// ===== rtl/color_literal_scanner_top.sv =====
// Top level of the colour literal scanner: classifier, token queue, matcher.
// Depends on cls_pkg, cls_front, cls_queue and cls_back.
//
//   channel  | dir | word contents
//   s_       | in  | tdata[7:0] text_byte, tuser first_of_file, tlast last_of_file
//   m_       | out | tdata line[23:0] column[39:24] length[55:40], tuser hit_kind
//   cfg_     | in  | wr_data snippet_limit, taken whenever wr_en is high
//
// One character per cycle unless m_ stalls; an accepted character is queued until
// the matcher takes it, and its hit, if any, is on m_ in the cycle after that.
// The matcher takes a token whenever the output register is empty or being read.
// A four-word queue absorbs output stalls before s_tready drops.
// Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module color_literal_scanner_top
    import cls_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LIMIT_BITS-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] text_byte
    input  wire logic                  s_tuser,   // [0] first_of_file
    input  wire logic                  s_tlast,   // last_of_file
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [23:0] hit_line, [39:24] hit_column, [55:40] hit_length
    output logic [LINE_NUMBER_BITS+2*COLUMN_BITS-1:0] m_tdata,
    output logic                       m_tuser    // [0] hit_kind
);

    logic   queue_full;
    logic   push;
    token_t push_token;
    logic   pop;
    logic   head_valid;
    token_t head_token;

    cls_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    cls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    cls_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_token  (head_token),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
